@@ rtl/sawtooth_pcm_frame_generator_defines.svh @@
// assertion macros for the sawtooth pcm frame generator checker
// no dependencies; expects clk and arst_n in the including scope
`ifndef SAWTOOTH_PCM_FRAME_GENERATOR_DEFINES_SVH
`define SAWTOOTH_PCM_FRAME_GENERATOR_DEFINES_SVH

// same-cycle implication
`define SFG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfg check failed");

// next-cycle implication
`define SFG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfg check failed");

`endif

@@ rtl/sfg_pkg.sv @@
// shared types and constants for the sawtooth pcm frame generator
// no dependencies
package sfg_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int ACC_W       = 32;
	localparam int FCNT_W      = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_BYTES    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_BITS   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_FRAMES = 3'd4;

	localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
	localparam logic [2:0]  RST_SLOT_BYTES    = 3'd2;
	localparam logic [5:0]  RST_SAMPLE_BITS   = 6'd16;
	localparam logic [31:0] RST_PHASE_STEP    = 32'd16777216;
	localparam logic [16:0] RST_BUFFER_FRAMES = 17'd480;

	// clamped, ready-to-use configuration
	typedef struct packed {
		logic [4:0]        chans;
		logic [2:0]        sbytes;
		logic [ACC_W-1:0]  keep_mask;
		logic [4:0]        slot_sh;
		logic [ACC_W-1:0]  step;
		logic [FCNT_W-1:0] last_frame;
	} cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0] slot;
		logic             buf_end;
	} frame_t;

endpackage

@@ rtl/sfg_queue.sv @@
// two-entry frame queue between front and back
// depends on sfg_pkg
module sfg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfg_pkg::frame_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output sfg_pkg::frame_t pop_data
);
	import sfg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/sfg_front.sv @@
// request front end: phase accumulator, frame counter, slot formation
// depends on sfg_pkg
module sfg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sfg_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      load_phase,
	input  logic [sfg_pkg::ACC_W-1:0] phase_value,
	output logic                      push,
	output sfg_pkg::frame_t           push_data,
	input  logic                      q_full
);
	import sfg_pkg::*;

	logic [ACC_W-1:0]  acc_q;
	logic [FCNT_W-1:0] fcnt_q;
	logic [ACC_W-1:0]  acc_cur;
	logic              buf_end;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign acc_cur  = load_phase ? phase_value : acc_q;
	assign buf_end  = (fcnt_q >= cfg.last_frame);

	// keep the top bits, then left-justify inside the slot
	assign push_data.slot    = (acc_cur & cfg.keep_mask) >> cfg.slot_sh;
	assign push_data.buf_end = buf_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fcnt_q <= '0;
		end else if (push) begin
			acc_q  <= acc_cur + cfg.step;
			fcnt_q <= buf_end ? '0 : fcnt_q + 1'b1;
		end
	end

endmodule

@@ rtl/sfg_back.sv @@
// byte serializer: walks channels and slot bytes of each queued frame
// depends on sfg_pkg
module sfg_back #(
	parameter int MAX_CHANNELS   = 8,
	parameter int MAX_SLOT_BYTES = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sfg_pkg::cfg_t   cfg,
	input  logic            pop_valid,
	input  sfg_pkg::frame_t pop_data,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      sample_byte,
	output logic [2:0]      channel_index,
	output logic [1:0]      byte_index,
	output logic            last_of_frame,
	output logic            last_of_buffer
);
	import sfg_pkg::*;

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int BY_W = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;

	frame_t          frame_q;
	logic            active_q;
	logic [CH_W-1:0] ch_q;
	logic [BY_W-1:0] by_q;
	logic            out_valid_q;
	logic [7:0]      sample_byte_q;
	logic [2:0]      channel_index_q;
	logic [1:0]      byte_index_q;
	logic            lof_q;
	logic            lob_q;
	logic            last_byte;
	logic            last_chan;
	logic            last;
	logic            advance;

	assign last_byte = (by_q == BY_W'(cfg.sbytes - 3'd1));
	assign last_chan = (ch_q == CH_W'(cfg.chans - 5'd1));
	assign last      = last_byte && last_chan;
	assign advance   = active_q && (!out_valid_q || out_ready);
	assign pop       = pop_valid && (!active_q || (advance && last));

	assign out_valid      = out_valid_q;
	assign sample_byte    = sample_byte_q;
	assign channel_index  = channel_index_q;
	assign byte_index     = byte_index_q;
	assign last_of_frame  = lof_q;
	assign last_of_buffer = lob_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= pop_data;
		end
		if (advance) begin
			sample_byte_q   <= frame_q.slot[{by_q, 3'b000} +: 8];
			channel_index_q <= 3'(ch_q);
			byte_index_q    <= 2'(by_q);
			lof_q           <= last;
			lob_q           <= last && frame_q.buf_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			ch_q        <= '0;
			by_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (pop) begin
				active_q <= 1'b1;
				ch_q     <= '0;
				by_q     <= '0;
			end else if (advance) begin
				if (last) begin
					active_q <= 1'b0;
				end
				if (last_byte) begin
					by_q <= '0;
					ch_q <= ch_q + 1'b1;
				end else begin
					by_q <= by_q + 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/sawtooth_pcm_frame_generator.sv @@
// sawtooth pcm frame generator: config registers, front, queue, back
// a request passes the queue, the back-end frame register and the output register
// throughput: one byte per cycle while out_ready is high and a frame is queued;
// a frame of channels x slot bytes bytes, paced by the back-end serializer
// a request is taken in any cycle the two-entry queue has room
// reset: accumulator and frame counter to zero, registers to defaults, queue empty
module sawtooth_pcm_frame_generator #(
	parameter int MAX_CHANNELS   = 8,
	parameter int MAX_SLOT_BYTES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [sfg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sfg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            load_phase,
	input  logic [31:0]                     phase_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      sample_byte,
	output logic [2:0]                      channel_index,
	output logic [1:0]                      byte_index,
	output logic                            last_of_frame,
	output logic                            last_of_buffer
);
	import sfg_pkg::*;

	logic [3:0]  channel_count_q;
	logic [2:0]  slot_bytes_q;
	logic [5:0]  sample_bits_q;
	logic [31:0] phase_step_q;
	logic [16:0] buffer_frames_q;
	cfg_t        cfg;
	logic [5:0]  slot_width;
	logic [5:0]  eff_bits;
	logic [4:0]  mask_sh;
	logic [4:0]  slot_sh;
	logic        push;
	frame_t      push_data;
	logic        q_full;
	logic        pop;
	logic        pop_valid;
	frame_t      pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= RST_CHANNEL_COUNT;
			slot_bytes_q    <= RST_SLOT_BYTES;
			sample_bits_q   <= RST_SAMPLE_BITS;
			phase_step_q    <= RST_PHASE_STEP;
			buffer_frames_q <= RST_BUFFER_FRAMES;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[3:0];
				REG_SLOT_BYTES:    slot_bytes_q    <= cfg_data[2:0];
				REG_SAMPLE_BITS:   sample_bits_q   <= cfg_data[5:0];
				REG_PHASE_STEP:    phase_step_q    <= cfg_data;
				REG_BUFFER_FRAMES: buffer_frames_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (channel_count_q == '0) begin
			cfg.chans = 5'd1;
		end else if (5'(channel_count_q) > 5'(MAX_CHANNELS)) begin
			cfg.chans = 5'(MAX_CHANNELS);
		end else begin
			cfg.chans = 5'(channel_count_q);
		end

		priority if (slot_bytes_q == '0) begin
			cfg.sbytes = 3'd1;
		end else if (slot_bytes_q > 3'(MAX_SLOT_BYTES)) begin
			cfg.sbytes = 3'(MAX_SLOT_BYTES);
		end else begin
			cfg.sbytes = slot_bytes_q;
		end

		slot_width = {cfg.sbytes, 3'b000};
		if ((sample_bits_q == '0) || (sample_bits_q > slot_width)) begin
			eff_bits = slot_width;
		end else begin
			eff_bits = sample_bits_q;
		end

		mask_sh       = 5'(6'd32 - eff_bits);
		slot_sh       = 5'(6'd32 - slot_width);
		cfg.keep_mask = {ACC_W{1'b1}} << mask_sh;
		cfg.slot_sh   = slot_sh;
		cfg.step      = phase_step_q;

		priority if (buffer_frames_q == '0) begin
			cfg.last_frame = '0;
		end else if (buffer_frames_q > 17'd65536) begin
			cfg.last_frame = '1;
		end else begin
			cfg.last_frame = 16'(buffer_frames_q - 17'd1);
		end
	end

	sfg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.load_phase  (load_phase),
		.phase_value (phase_value),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	sfg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	sfg_back #(
		.MAX_CHANNELS   (MAX_CHANNELS),
		.MAX_SLOT_BYTES (MAX_SLOT_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.pop_valid      (pop_valid),
		.pop_data       (pop_data),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_byte    (sample_byte),
		.channel_index  (channel_index),
		.byte_index     (byte_index),
		.last_of_frame  (last_of_frame),
		.last_of_buffer (last_of_buffer)
	);

endmodule

@@ rtl/sfg_checker.sv @@
// port-level checks for the sawtooth pcm frame generator, bound to the top level
// depends on sawtooth_pcm_frame_generator_defines.svh
`include "sawtooth_pcm_frame_generator_defines.svh"

module sfg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] sample_byte,
	input logic [2:0] channel_index,
	input logic [1:0] byte_index,
	input logic       last_of_frame,
	input logic       last_of_buffer
);

	`SFG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_byte) && $stable(channel_index) && $stable(byte_index) && $stable(last_of_frame) && $stable(last_of_buffer))
	`SFG_ASSERT_NOW(a_buf_in_frame, out_valid && last_of_buffer, last_of_frame)
	`SFG_ASSERT_NEXT(a_frame_contig, out_valid && out_ready && !last_of_frame, out_valid)
	`SFG_ASSERT_NEXT(a_frame_start, out_valid && out_ready && last_of_frame, !out_valid || (byte_index == 2'd0 && channel_index == 3'd0))

endmodule

bind sawtooth_pcm_frame_generator sfg_checker u_sfg_checker (.*);
